[rtl/multiset_permutation_ranker_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the multiset permutation ranker.
// Full property checks in simulation, empty under SYNTH.
// ---------------------------------------------------------------------------
`ifndef MULTISET_PERMUTATION_RANKER_TOP_ASSERT_SVH
`define MULTISET_PERMUTATION_RANKER_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication or plain property, disabled during reset.
`define MPR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MPR_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define MPR_ASSERT(lbl, clk, rst, prop, msg)
`define MPR_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)

`endif

`endif

[rtl/mpr_pkg.sv]
// ---------------------------------------------------------------------------
// mpr_pkg
// Types, constants and helpers shared by the multiset permutation ranker.
// ---------------------------------------------------------------------------
`default_nettype none

package mpr_pkg;

   localparam int unsigned COUNT_W    = 4;
   localparam int unsigned LEN_W      = 5;
   localparam int unsigned RANK_W     = 34;
   localparam int unsigned DIVISOR_W  = 5;
   localparam int unsigned DIVIDEND_W = 39;   // 34-bit count times 5-bit factor
   localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
   localparam int unsigned CSR_IDX_W  = 2;

   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [LEN_W-1:0]      len_type;
   typedef logic [RANK_W-1:0]     rank_type;
   typedef logic [DIVISOR_W-1:0]  divisor_type;
   typedef logic [DIVIDEND_W-1:0] dividend_type;
   typedef logic [DIV_CNT_W-1:0]  div_cnt_type;

   localparam count_type MAX_PER_SYMBOL = 4'd8;
   localparam count_type COUNT_A_RST    = 4'd7;
   localparam count_type COUNT_B_RST    = 4'd8;
   localparam count_type COUNT_C_RST    = 4'd8;

   // Symbol codes
   localparam logic [1:0] SYM_A    = 2'd0;
   localparam logic [1:0] SYM_NONE = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_C = 2'd2;

   typedef struct packed {
      logic [1:0] symbol;
      logic       start_req;
   } req_type;

   typedef struct packed {
      rank_type rank_so_far;
      logic     done_res;
      logic     bad_symbol;
   } rsp_type;

   typedef struct packed {
      logic         start;
      dividend_type dividend;
      divisor_type  divisor;
   } div_req_type;

   typedef struct packed {
      logic     busy;
      logic     done;
      rank_type quotient;
   } div_rsp_type;

   function automatic count_type clamp_count(input count_type v);
      return (v > MAX_PER_SYMBOL) ? MAX_PER_SYMBOL : v;
   endfunction

endpackage

`default_nettype wire

[rtl/mpr_div.sv]
// ---------------------------------------------------------------------------
// mpr_div
// Restoring divider, one quotient bit per cycle. Quotient is truncated to
// the rank width; done pulses for one cycle with the quotient valid.
// ---------------------------------------------------------------------------
`default_nettype none
`include "multiset_permutation_ranker_top_assert.svh"

module mpr_div (
   input  wire                       clock,
   input  wire                       reset,
   input  wire mpr_pkg::div_req_type div_req,
   output mpr_pkg::div_rsp_type      div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   mpr_pkg::div_cnt_type  cnt_ff, cnt_in;
   mpr_pkg::divisor_type  rem_ff, rem_in;
   mpr_pkg::divisor_type  dsr_ff, dsr_in;
   mpr_pkg::dividend_type quo_ff, quo_in;

   logic [mpr_pkg::DIVISOR_W:0] trial;
   logic [mpr_pkg::DIVISOR_W:0] diff;
   logic                        q_bit;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;

      // remainder stays below the divisor, so it fits the divisor width
      trial = {rem_ff, quo_ff[mpr_pkg::DIVIDEND_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      q_bit = (trial >= {1'b0, dsr_ff});

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = mpr_pkg::div_cnt_type'(mpr_pkg::DIVIDEND_W);
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = q_bit ? diff[mpr_pkg::DIVISOR_W-1:0] : trial[mpr_pkg::DIVISOR_W-1:0];
         quo_in = {quo_ff[mpr_pkg::DIVIDEND_W-2:0], q_bit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == mpr_pkg::div_cnt_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[mpr_pkg::RANK_W-1:0];

   `MPR_ASSERT(a_div_start_idle, clock, reset, div_req.start |-> !busy_ff,
      "divider restarted while busy")
   `MPR_ASSERT_NEXT(a_div_start_busy, clock, reset, div_req.start, busy_ff,
      "divider did not start")
   `MPR_ASSERT(a_div_nonzero, clock, reset, busy_ff |-> (dsr_ff != '0),
      "division by zero")

endmodule

`default_nettype wire

[rtl/multiset_permutation_ranker_top.sv]
// ---------------------------------------------------------------------------
// multiset_permutation_ranker_top
// Lexicographic rank of a string over a<b<c among all arrangements of the
// configured letter counts, one symbol per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one symbol per transfer; start_req reloads the counts from the
//            csr registers (clamped to 8) and clears the rank.
//   rsp_*  : one result per request: running rank, done at the last symbol,
//            bad_symbol when the symbol is not available (state unchanged).
//   csr_*  : count_a/b/c at index 0/1/2, always ready; write while idle.
// Arithmetic: all multiplications and divisions go through one shared
//   multiply-then-divide unit; the restoring divider yields one quotient bit
//   per cycle. A symbol needs d = 1..3 divisions (one per smaller available
//   letter plus one); a rejected symbol needs none. A start adds one
//   division per letter of the string for the multinomial reload.
// The request side is not ready while a symbol is in work. A finished result
// sits in an output register; a new request is taken while it waits, and a
// stalled receiver holds the next result in the final state until taken.
// Reset (synchronous) clears counts to 7/8/8, the remaining letters, length
// and rank to zero; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
`include "multiset_permutation_ranker_top_assert.svh"

module multiset_permutation_ranker_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  mpr_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output mpr_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [mpr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [mpr_pkg::COUNT_W-1:0]         csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MN_NEXT,
      ST_MN_WAIT,
      ST_CHECK,
      ST_RANK_NEXT,
      ST_RANK_WAIT,
      ST_ARR_WAIT,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   mpr_pkg::count_type cnt_a_ff, cnt_a_in;
   mpr_pkg::count_type cnt_b_ff, cnt_b_in;
   mpr_pkg::count_type cnt_c_ff, cnt_c_in;

   mpr_pkg::count_type letters_ff [3];
   mpr_pkg::count_type letters_in [3];
   mpr_pkg::len_type   len_ff, len_in;
   mpr_pkg::rank_type  arr_ff, arr_in;
   mpr_pkg::rank_type  rank_ff, rank_in;

   logic [1:0]         sym_ff, sym_in;
   logic [1:0]         k_ff, k_in;        // multinomial letter index
   mpr_pkg::count_type i_ff, i_in;        // multinomial inner step
   mpr_pkg::len_type   total_ff, total_in;
   logic [1:0]         x_ff, x_in;        // letter index, scanned up to the symbol
   logic               res_done_ff, res_done_in;
   logic               res_bad_ff, res_bad_in;

   logic               rsp_valid_ff, rsp_valid_in;
   mpr_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [1:0]            rd_idx;
   mpr_pkg::count_type    letter_rd;
   mpr_pkg::len_type      factor;
   logic                  div_start;
   mpr_pkg::dividend_type div_dividend;
   mpr_pkg::divisor_type  div_divisor;
   mpr_pkg::div_req_type  div_req;
   mpr_pkg::div_rsp_type  div_rsp;

   mpr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign div_req = '{start: div_start, dividend: div_dividend, divisor: div_divisor};

   // shared read port on the remaining letter counts
   always_comb begin
      unique case (state_ff)
         ST_MN_NEXT:   rd_idx = k_ff;
         ST_RANK_NEXT: rd_idx = x_ff;
         default:      rd_idx = sym_ff;
      endcase
      letter_rd = (rd_idx == mpr_pkg::SYM_NONE) ? '0 : letters_ff[rd_idx];
      factor    = (state_ff == ST_MN_NEXT) ? (total_ff + 5'd1)
                                           : mpr_pkg::len_type'(letter_rd);
      div_dividend = mpr_pkg::dividend_type'(arr_ff) * mpr_pkg::dividend_type'(factor);
      div_divisor  = (state_ff == ST_MN_NEXT) ? mpr_pkg::divisor_type'(i_ff) : len_ff;
   end

   always_comb begin
      state_in    = state_ff;
      cnt_a_in    = cnt_a_ff;
      cnt_b_in    = cnt_b_ff;
      cnt_c_in    = cnt_c_ff;
      letters_in  = letters_ff;
      len_in      = len_ff;
      arr_in      = arr_ff;
      rank_in     = rank_ff;
      sym_in      = sym_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      total_in    = total_ff;
      x_in        = x_ff;
      res_done_in = res_done_ff;
      res_bad_in  = res_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            mpr_pkg::CSR_COUNT_A: cnt_a_in = csr_wdata;
            mpr_pkg::CSR_COUNT_B: cnt_b_in = csr_wdata;
            mpr_pkg::CSR_COUNT_C: cnt_c_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sym_in = req_data.symbol;
               if (req_data.start_req) begin
                  letters_in[0] = mpr_pkg::clamp_count(cnt_a_ff);
                  letters_in[1] = mpr_pkg::clamp_count(cnt_b_ff);
                  letters_in[2] = mpr_pkg::clamp_count(cnt_c_ff);
                  len_in   = mpr_pkg::len_type'(letters_in[0]) +
                             mpr_pkg::len_type'(letters_in[1]) +
                             mpr_pkg::len_type'(letters_in[2]);
                  rank_in  = '0;
                  arr_in   = mpr_pkg::rank_type'(1);
                  k_in     = mpr_pkg::SYM_A;
                  i_in     = mpr_pkg::count_type'(1);
                  total_in = '0;
                  state_in = ST_MN_NEXT;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         // multinomial: arr = arr * (total+1) / i over every letter
         ST_MN_NEXT: begin
            if (k_ff == mpr_pkg::SYM_NONE) begin
               state_in = ST_CHECK;
            end else if (i_ff > letter_rd) begin
               k_in = k_ff + 2'd1;
               i_in = mpr_pkg::count_type'(1);
            end else begin
               div_start = 1'b1;
               state_in  = ST_MN_WAIT;
            end
         end
         ST_MN_WAIT: begin
            if (div_rsp.done) begin
               arr_in   = div_rsp.quotient;
               i_in     = i_ff + 4'd1;
               total_in = total_ff + 5'd1;
               state_in = ST_MN_NEXT;
            end
         end
         ST_CHECK: begin
            if (sym_ff == mpr_pkg::SYM_NONE || letter_rd == '0 || len_ff == '0) begin
               res_done_in = 1'b0;
               res_bad_in  = 1'b1;
               state_in    = ST_RESP;
            end else begin
               x_in     = mpr_pkg::SYM_A;
               state_in = ST_RANK_NEXT;
            end
         end
         ST_RANK_NEXT: begin
            if (x_ff == sym_ff) begin
               div_start = 1'b1;
               state_in  = ST_ARR_WAIT;
            end else if (letter_rd != '0) begin
               div_start = 1'b1;
               state_in  = ST_RANK_WAIT;
            end else begin
               x_in = x_ff + 2'd1;
            end
         end
         ST_RANK_WAIT: begin
            if (div_rsp.done) begin
               rank_in  = rank_ff + div_rsp.quotient;
               x_in     = x_ff + 2'd1;
               state_in = ST_RANK_NEXT;
            end
         end
         ST_ARR_WAIT: begin
            if (div_rsp.done) begin
               arr_in              = div_rsp.quotient;
               letters_in[sym_ff]  = letters_ff[sym_ff] - 4'd1;
               len_in              = len_ff - 5'd1;
               res_done_in         = (len_ff == 5'd1);
               res_bad_in          = 1'b0;
               state_in            = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{rank_so_far: rank_ff,
                                done_res:    res_done_ff,
                                bad_symbol:  res_bad_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= mpr_pkg::COUNT_A_RST;
         cnt_b_ff     <= mpr_pkg::COUNT_B_RST;
         cnt_c_ff     <= mpr_pkg::COUNT_C_RST;
         letters_ff   <= '{default: '0};
         len_ff       <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         cnt_c_ff     <= cnt_c_in;
         letters_ff   <= letters_in;
         len_ff       <= len_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      arr_ff      <= arr_in;
      sym_ff      <= sym_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      total_ff    <= total_in;
      x_ff        <= x_in;
      res_done_ff <= res_done_in;
      res_bad_ff  <= res_bad_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MPR_ASSERT(a_bad_not_done, clock, reset,
      rsp_valid_ff |-> !(rsp_data_ff.done_res && rsp_data_ff.bad_symbol),
      "result both done and rejected")
   `MPR_ASSERT(a_len_tracks, clock, reset,
      (state_ff == ST_IDLE) |-> (len_ff == mpr_pkg::len_type'(letters_ff[0]) +
         mpr_pkg::len_type'(letters_ff[1]) + mpr_pkg::len_type'(letters_ff[2])),
      "remaining length out of step with letter counts")
   `MPR_ASSERT(a_launch_free, clock, reset, div_req.start |-> !div_rsp.busy,
      "division launched on a busy unit")
   `MPR_ASSERT(a_done_waited, clock, reset,
      div_rsp.done |-> (state_ff == ST_MN_WAIT || state_ff == ST_RANK_WAIT ||
         state_ff == ST_ARR_WAIT),
      "quotient arrived outside a wait state")

endmodule

`default_nettype wire
